FILE: design/cobs_console_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the COBS console frame receiver
// Clocked assertion shorthands, disabled while the block is in reset.
// ----------------------------------------------------------------------------
`ifndef COBS_CONSOLE_FRAME_RECEIVER_ASSERT_SVH
`define COBS_CONSOLE_FRAME_RECEIVER_ASSERT_SVH

// The property must hold at every clock edge out of reset.
`define CCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared codes, constants and word types of the COBS console frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccfr_pkg;

  localparam logic [1:0] OP_LINK = 2'd0;
  localparam logic [1:0] OP_KEY  = 2'd1;
  localparam logic [1:0] OP_CODE = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_KEY   = 2'd2;
  localparam logic [1:0] CMD_CODE  = 2'd3;

  localparam int FRAME_LEN = 16;
  localparam int CODE_LEN  = 15;
  localparam int KEY_COUNT = 56;
  localparam int DEC_BAD   = 17;

  localparam logic [7:0] KIND_KEYS = 8'd1;
  localparam logic [7:0] KIND_CODE = 8'd2;
  localparam logic [7:0] COBS_MAX  = 8'hFF;

  localparam logic [KEY_COUNT-1:0] KEY_MASK =
    {8'h0F, 8'hFF, 8'hFF, 8'h0F, 8'h3F, 8'h1F, 8'hFF};

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            frame_kind;
    logic [CODE_LEN*8-1:0] payload;
    logic [5:0]            key_index;
    logic                  clear_event;
    logic [3:0]            code_index;
  } cmd_t;

  typedef struct packed {
    logic       frame_accepted;
    logic [7:0] frame_kind;
    logic       key_down;
    logic       key_event;
    logic [7:0] code_byte;
  } result_t;

endpackage

`default_nettype wire

FILE: design/ccfr_fifo.sv
// ----------------------------------------------------------------------------
// ccfr_fifo
// Small first-in first-out queue of words with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccfr_fifo #(
  parameter type item_t = logic [7:0],
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ccfr_front.sv
// ----------------------------------------------------------------------------
// ccfr_front
// Accepts input words, assembles and COBS-decodes link frames on the fly,
// and issues one command word per input word to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cobs_console_frame_receiver_assert.svh"

module ccfr_front #(
  parameter int RAW_LIMIT = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_data,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     op,
  input  logic [7:0]     rx_byte,
  input  logic [5:0]     key_index,
  input  logic           clear_event,
  input  logic [3:0]     code_index,
  output ccfr_pkg::cmd_t cmd,
  output logic           cmd_push,
  input  logic           cmd_full
);
  import ccfr_pkg::*;

  localparam int RAW_W = $clog2(RAW_LIMIT);

  logic [7:0]       delim;
  logic [RAW_W-1:0] raw_count;
  logic [RAW_W-1:0] raw_count_next;
  logic [7:0]       block_remaining;
  logic [7:0]       block_remaining_next;
  logic [7:0]       block_code;
  logic [7:0]       block_code_next;
  logic [4:0]       decoded_count;
  logic [4:0]       decoded_count_next;
  logic [7:0]       decoded_bytes [FRAME_LEN];

  logic       take;
  logic       link;
  logic       frame_ok;
  logic       dec_wr;
  logic [7:0] dec_data;

  assign full     = cmd_full;
  assign take     = push && !full;
  assign link     = take && (op == OP_LINK);
  assign cmd_push = take;

  always_comb begin
    raw_count_next       = raw_count;
    block_remaining_next = block_remaining;
    block_code_next      = block_code;
    decoded_count_next   = decoded_count;
    dec_wr               = 1'b0;
    dec_data             = 8'd0;
    frame_ok             = 1'b0;
    if (link) begin
      if (rx_byte == delim) begin
        frame_ok = (raw_count != '0) && (block_remaining == 8'd0) &&
                   (decoded_count == 5'(FRAME_LEN));
        raw_count_next       = '0;
        block_remaining_next = 8'd0;
        block_code_next      = 8'd0;
        decoded_count_next   = 5'd0;
      end else if (raw_count < RAW_W'(RAW_LIMIT - 1)) begin
        raw_count_next = raw_count + 1'b1;
        if (block_remaining == 8'd0) begin
          dec_wr          = (block_code != 8'd0) && (block_code != COBS_MAX);
          block_code_next = rx_byte;
          block_remaining_next = (rx_byte == 8'd0) ? 8'd0 : rx_byte - 8'd1;
        end else begin
          dec_wr               = 1'b1;
          dec_data             = rx_byte;
          block_remaining_next = block_remaining - 8'd1;
        end
        if (dec_wr && (decoded_count < 5'(DEC_BAD))) begin
          decoded_count_next = decoded_count + 5'd1;
        end
        if ((block_remaining == 8'd0) && (rx_byte == 8'd0)) begin
          decoded_count_next = 5'(DEC_BAD);
        end
      end else begin
        raw_count_next       = '0;
        block_remaining_next = 8'd0;
        block_code_next      = 8'd0;
        decoded_count_next   = 5'd0;
      end
    end
  end

  always_comb begin
    cmd.frame_kind  = decoded_bytes[0];
    cmd.key_index   = key_index;
    cmd.clear_event = clear_event;
    cmd.code_index  = code_index;
    for (int i = 0; i < CODE_LEN; i++) begin
      cmd.payload[8*i +: 8] = decoded_bytes[i+1];
    end
    case (op)
      OP_LINK: cmd.kind = frame_ok ? CMD_FRAME : CMD_NONE;
      OP_KEY:  cmd.kind = CMD_KEY;
      OP_CODE: cmd.kind = CMD_CODE;
      default: cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dec_wr && (decoded_count < 5'(FRAME_LEN))) begin
      decoded_bytes[decoded_count[3:0]] <= dec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim           <= 8'd0;
      raw_count       <= '0;
      block_remaining <= 8'd0;
      block_code      <= 8'd0;
      decoded_count   <= 5'd0;
    end else begin
      if (cfg_write) begin
        delim <= cfg_data;
      end
      raw_count       <= raw_count_next;
      block_remaining <= block_remaining_next;
      block_code      <= block_code_next;
      decoded_count   <= decoded_count_next;
    end
  end

  `CCFR_ASSERT_ALWAYS(a_dec_count_range, decoded_count <= 5'(DEC_BAD), "decoded count overrun")
  `CCFR_ASSERT_ALWAYS(a_no_block_no_rem, (block_code != 8'd0) || (block_remaining == 8'd0), "data expected without a code byte")
  `CCFR_ASSERT_NEXT(a_delim_clears, link && (rx_byte == delim), (raw_count == '0) && (decoded_count == 5'd0), "frame not cleared at delimiter")

endmodule

`default_nettype wire

FILE: design/ccfr_back.sv
// ----------------------------------------------------------------------------
// ccfr_back
// Executes command words: applies accepted frames to the key and code state,
// answers key queries and code reads, and forms one result word per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cobs_console_frame_receiver_assert.svh"

module ccfr_back (
  input  logic              clk,
  input  logic              rst,
  input  ccfr_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output ccfr_pkg::result_t res,
  output logic              res_push,
  input  logic              res_full
);
  import ccfr_pkg::*;

  logic [KEY_COUNT-1:0] held_keys;
  logic [KEY_COUNT-1:0] press_events;
  logic [7:0]           code_store [CODE_LEN];

  logic                 go;
  logic [KEY_COUNT-1:0] key_now;
  logic                 key_ok;
  logic                 key_down;
  logic                 key_event;
  logic                 code_ok;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  assign key_now   = cmd.payload[KEY_COUNT-1:0] & KEY_MASK;
  assign key_ok    = (cmd.key_index < 6'(KEY_COUNT));
  assign key_down  = key_ok && held_keys[cmd.key_index];
  assign key_event = key_ok && press_events[cmd.key_index];
  assign code_ok   = (cmd.code_index < 4'(CODE_LEN));

  always_comb begin
    res = '0;
    case (cmd.kind)
      CMD_FRAME: begin
        res.frame_accepted = 1'b1;
        res.frame_kind     = cmd.frame_kind;
      end
      CMD_KEY: begin
        res.key_down  = key_down;
        res.key_event = key_event;
      end
      CMD_CODE: begin
        res.code_byte = code_ok ? code_store[cmd.code_index] : 8'd0;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_keys    <= '0;
      press_events <= '0;
      for (int i = 0; i < CODE_LEN; i++) begin
        code_store[i] <= 8'd0;
      end
    end else if (go) begin
      if (cmd.kind == CMD_FRAME) begin
        if (cmd.frame_kind == KIND_KEYS) begin
          press_events <= press_events | (key_now & ~held_keys);
          held_keys    <= key_now;
        end else if (cmd.frame_kind == KIND_CODE) begin
          for (int i = 0; i < CODE_LEN; i++) begin
            code_store[i] <= cmd.payload[8*i +: 8];
          end
        end
      end else if ((cmd.kind == CMD_KEY) && key_event && cmd.clear_event) begin
        press_events[cmd.key_index] <= 1'b0;
      end
    end
  end

  `CCFR_ASSERT_ALWAYS(a_held_masked, (held_keys & ~KEY_MASK) == '0, "held key outside mask")
  `CCFR_ASSERT_ALWAYS(a_press_masked, (press_events & ~KEY_MASK) == '0, "press event outside mask")
  `CCFR_ASSERT_NEXT(a_keys_loaded, go && (cmd.kind == CMD_FRAME) && (cmd.frame_kind == KIND_KEYS), held_keys == $past(key_now), "key frame not applied")

endmodule

`default_nettype wire

FILE: design/cobs_console_frame_receiver.sv
// ----------------------------------------------------------------------------
// cobs_console_frame_receiver
// Console link receiver: COBS frame decoding, key state and code storage.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while full is low and gives one
// result word for each, in order. The front end decodes one link byte per
// cycle unless stalled and the back end applies a whole 56-key update at
// once, so the sustained rate is one word per cycle as long as results are
// popped. Two-entry queues sit between front and back and in front of the
// result ports. The user must write the frame delimiter through cfg_write
// and cfg_data only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module cobs_console_frame_receiver #(
  parameter int RAW_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  input  logic [5:0] key_index,
  input  logic       clear_event,
  input  logic [3:0] code_index,
  output logic       empty,
  input  logic       pop,
  output logic       frame_accepted,
  output logic [7:0] frame_kind,
  output logic       key_down,
  output logic       key_event,
  output logic [7:0] code_byte
);
  import ccfr_pkg::*;

  cmd_t    front_cmd;
  logic    front_push;
  logic    cmd_full;
  cmd_t    back_cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t back_res;
  logic    res_push;
  logic    res_full;
  result_t head;

  ccfr_front #(
    .RAW_LIMIT(RAW_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .op         (op),
    .rx_byte    (rx_byte),
    .key_index  (key_index),
    .clear_event(clear_event),
    .code_index (code_index),
    .cmd        (front_cmd),
    .cmd_push   (front_push),
    .cmd_full   (cmd_full)
  );

  ccfr_fifo #(
    .item_t(cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_push),
    .wr_data(front_cmd),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(back_cmd),
    .empty  (cmd_empty)
  );

  ccfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (back_cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (back_res),
    .res_push (res_push),
    .res_full (res_full)
  );

  ccfr_fifo #(
    .item_t(result_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .rd_en  (pop && !empty),
    .rd_data(head),
    .empty  (empty)
  );

  assign frame_accepted = head.frame_accepted;
  assign frame_kind     = head.frame_kind;
  assign key_down       = head.key_down;
  assign key_event      = head.key_event;
  assign code_byte      = head.code_byte;

endmodule

`default_nettype wire

FILE: tb/cobs_console_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// cobs_console_frame_receiver_test
// Self-checking bench for the COBS console frame receiver.
// ----------------------------------------------------------------------------
// A short table of directed words runs first with the delimiter at its reset
// value. Six random phases follow, each under a delimiter written at its
// start; the idling pattern changes every two phases. Each phase is mostly
// COBS frames, most of the key and code kinds, with random content, mixed
// with broken frames, raw overflows, key queries and code reads. A local
// predictor follows the block's state and gives the expected result for
// every accepted word. Results come back in order, compared field by field.
`timescale 1ns / 1ps

module cobs_console_frame_receiver_test;
  import ccfr_pkg::*;

  localparam int RAW_LIMIT = 64;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int DAMAGE_NONE      = 0;
  localparam int DAMAGE_TRUNCATE  = 1;
  localparam int DAMAGE_ZERO_CODE = 2;

  localparam int PHASE_WORDS = 100;
  localparam int NUM_PHASES  = 6;

  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic [5:0] key;
    logic       clr;
    logic [3:0] ci;
  } in_word_t;

  typedef struct packed {
    in_word_t w;
    logic     typed;
    result_t  exp;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] op = OP_NOP;
  logic [7:0] rx_byte = 8'h00;
  logic [5:0] key_index = 6'd0;
  logic       clear_event = 1'b0;
  logic [3:0] code_index = 4'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic       frame_accepted;
  logic [7:0] frame_kind;
  logic       key_down;
  logic       key_event;
  logic [7:0] code_byte;

  cobs_console_frame_receiver #(
    .RAW_LIMIT(RAW_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .op(op),
    .rx_byte(rx_byte),
    .key_index(key_index),
    .clear_event(clear_event),
    .code_index(code_index),
    .empty(empty),
    .pop(pop),
    .frame_accepted(frame_accepted),
    .frame_kind(frame_kind),
    .key_down(key_down),
    .key_event(key_event),
    .code_byte(code_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Predicted receiver state.
  logic [7:0]          frame_delim = 8'h00;
  int                  raw_count = 0;
  logic [7:0]          blk_left = 8'h00;
  logic [7:0]          blk_code = 8'h00;
  logic [4:0]          dec_count = 5'd0;
  logic [7:0]          dec_bytes[FRAME_LEN];
  logic [KEY_COUNT-1:0] held = '0;
  logic [KEY_COUNT-1:0] pressed = '0;
  logic [7:0]          code_mem[CODE_LEN];

  stim_t   word_plan[$];
  result_t expected_results[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      mismatch_count = 0;
  int      words_sent = 0;
  int      frames_seen = 0;
  int      key_frames = 0;
  int      code_frames = 0;
  int      events_seen = 0;

  initial begin
    foreach (dec_bytes[i]) dec_bytes[i] = 8'h00;
    foreach (code_mem[i]) code_mem[i] = 8'h00;
  end

  function automatic void clear_frame();
    raw_count = 0;
    blk_left = 8'h00;
    blk_code = 8'h00;
    dec_count = 5'd0;
  endfunction

  function automatic void store_decoded(logic [7:0] b);
    if (dec_count < FRAME_LEN) dec_bytes[dec_count] = b;
    if (dec_count < DEC_BAD) dec_count++;
  endfunction

  function automatic result_t respond(in_word_t w);
    result_t r;
    logic [KEY_COUNT-1:0] now;
    r = '0;
    case (w.op)
      OP_LINK: begin
        if (w.rx == frame_delim) begin
          if (raw_count > 0 && blk_left == 0 && dec_count == FRAME_LEN) begin
            r.frame_accepted = 1'b1;
            r.frame_kind = dec_bytes[0];
            if (dec_bytes[0] == KIND_KEYS) begin
              now = {dec_bytes[7], dec_bytes[6], dec_bytes[5], dec_bytes[4],
                     dec_bytes[3], dec_bytes[2], dec_bytes[1]} & KEY_MASK;
              pressed = pressed | (now & ~held);
              held = now;
            end else if (dec_bytes[0] == KIND_CODE) begin
              for (int i = 0; i < CODE_LEN; i++) code_mem[i] = dec_bytes[i + 1];
            end
          end
          clear_frame();
        end else if (raw_count + 1 < RAW_LIMIT) begin
          raw_count++;
          if (blk_left == 0) begin
            if (blk_code != 8'h00 && blk_code != COBS_MAX) store_decoded(8'h00);
            if (w.rx == 8'h00) dec_count = DEC_BAD;
            blk_code = w.rx;
            blk_left = (w.rx == 8'h00) ? 8'h00 : w.rx - 8'd1;
          end else begin
            store_decoded(w.rx);
            blk_left--;
          end
        end else begin
          clear_frame();
        end
      end
      OP_KEY: begin
        if (w.key < KEY_COUNT) begin
          r.key_down = held[w.key];
          r.key_event = pressed[w.key];
          if (r.key_event && w.clr) pressed[w.key] = 1'b0;
        end
      end
      OP_CODE: begin
        if (w.ci < CODE_LEN) r.code_byte = code_mem[w.ci];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic bytes_t cobs_encode(bytes_t data);
    bytes_t enc;
    int code_pos;
    logic [7:0] run;
    enc.push_back(8'h00);
    code_pos = 0;
    run = 8'd1;
    foreach (data[i]) begin
      if (data[i] == 8'h00) begin
        enc[code_pos] = run;
        code_pos = enc.size();
        enc.push_back(8'h00);
        run = 8'd1;
      end else begin
        enc.push_back(data[i]);
        run++;
      end
    end
    enc[code_pos] = run;
    return enc;
  endfunction

  function automatic stim_t row(logic [1:0] o, logic [7:0] rx, logic [5:0] key,
                                logic clr, logic [3:0] ci, logic typed,
                                logic acc, logic [7:0] kind, logic down,
                                logic ev, logic [7:0] cb);
    stim_t s;
    s.w = '{op: o, rx: rx, key: key, clr: clr, ci: ci};
    s.typed = typed;
    s.exp = '{frame_accepted: acc, frame_kind: kind, key_down: down,
              key_event: ev, code_byte: cb};
    return s;
  endfunction

  function automatic void add_word(logic [1:0] o, logic [7:0] rx, logic [5:0] key,
                                   logic clr, logic [3:0] ci);
    word_plan.push_back(row(o, rx, key, clr, ci, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                            8'h00));
  endfunction

  function automatic void add_link(logic [7:0] b);
    add_word(OP_LINK, b, 6'($urandom), 1'($urandom), 4'($urandom));
  endfunction

  function automatic void add_frame(int len, int kind, int damage);
    bytes_t data;
    bytes_t enc;
    int tries;
    bit clash;
    tries = 0;
    do begin
      data = {};
      for (int i = 0; i < len; i++) begin
        data.push_back(($urandom_range(0, 99) < 20) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      if (kind >= 0) data[0] = 8'(kind);
      enc = cobs_encode(data);
      clash = 1'b0;
      foreach (enc[i]) if (enc[i] == frame_delim) clash = 1'b1;
      tries++;
    end while (clash && tries < 10);
    if (damage == DAMAGE_TRUNCATE) void'(enc.pop_back());
    if (damage == DAMAGE_ZERO_CODE) enc[0] = 8'h00;
    foreach (enc[i]) add_link(enc[i]);
    add_link(frame_delim);
  endfunction

  function automatic logic [7:0] non_delim_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == frame_delim);
    return b;
  endfunction

  function automatic void plan_random(int target);
    int pick;
    int kind;
    int n;
    while (word_plan.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(0, 99);
        kind = (n < 40) ? KIND_KEYS : (n < 75) ? KIND_CODE : $urandom_range(0, 255);
        add_frame(FRAME_LEN, kind, DAMAGE_NONE);
      end else if (pick < 57) begin
        case ($urandom_range(0, 5))
          0: add_frame(FRAME_LEN, KIND_KEYS, DAMAGE_TRUNCATE);
          1: add_frame(FRAME_LEN, KIND_CODE, DAMAGE_ZERO_CODE);
          2: add_frame($urandom_range(1, 15), KIND_KEYS, DAMAGE_NONE);
          3: add_frame($urandom_range(17, 22), KIND_CODE, DAMAGE_NONE);
          4: add_link(frame_delim);
          default: begin
            n = $urandom_range(RAW_LIMIT - 2, RAW_LIMIT + 3);
            repeat (n) add_link(non_delim_byte());
            if ($urandom_range(0, 1) == 1) add_link(frame_delim);
          end
        endcase
      end else if (pick < 77) begin
        add_word(OP_KEY, 8'($urandom),
                 ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, KEY_COUNT - 1))
                                              : 6'($urandom),
                 1'($urandom), 4'($urandom));
      end else if (pick < 92) begin
        add_word(OP_CODE, 8'($urandom), 6'($urandom), 1'($urandom),
                 4'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        add_word(OP_NOP, 8'($urandom), 6'($urandom), 1'($urandom), 4'($urandom));
      end else begin
        add_link(8'($urandom));
      end
    end
  endfunction

  task automatic write_delimiter(logic [7:0] d);
    cfg_write <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_delim = d;
  endtask

  task automatic send_plan();
    stim_t s;
    result_t r;
    while (word_plan.size() != 0) begin
      if ($urandom_range(0, 99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end else begin
        s = word_plan.pop_front();
        push <= 1'b1;
        op <= s.w.op;
        rx_byte <= s.w.rx;
        key_index <= s.w.key;
        clear_event <= s.w.clr;
        code_index <= s.w.ci;
        @(posedge clk);
        while (full) @(posedge clk);
        r = respond(s.w);
        if (s.typed) r = s.exp;
        expected_results.push_back(r);
        words_sent++;
        if (r.frame_accepted) frames_seen++;
        if (r.frame_accepted && r.frame_kind == KIND_KEYS) key_frames++;
        if (r.frame_accepted && r.frame_kind == KIND_CODE) code_frames++;
        if (r.key_event) events_seen++;
      end
    end
    push <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected result word: acc=%0d kind=%02h down=%0d ev=%0d code=%02h",
                     frame_accepted, frame_kind, key_down, key_event, code_byte);
          end
        end else begin
          want = expected_results.pop_front();
          if (frame_accepted !== want.frame_accepted || frame_kind !== want.frame_kind ||
              key_down !== want.key_down || key_event !== want.key_event ||
              code_byte !== want.code_byte) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected acc=%0d kind=%02h down=%0d ev=%0d code=%02h",
                       want.frame_accepted, want.frame_kind, want.key_down,
                       want.key_event, want.code_byte);
              $display("          actual   acc=%0d kind=%02h down=%0d ev=%0d code=%02h",
                       frame_accepted, frame_kind, key_down, key_event, code_byte);
            end
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [7:0] phase_delim[NUM_PHASES];
    phase_delim = '{8'hFF, 8'($urandom_range(1, 254)), 8'h00,
                    8'($urandom_range(1, 254)), 8'h01, 8'h00};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words run with the delimiter at its reset value of zero.
    send_idle_pct = 16;
    recv_idle_pct = 59;
    word_plan.push_back(row(OP_KEY, 8'h00, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_KEY, 8'h00, 6'd63, 1'b1, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_CODE, 8'h00, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_CODE, 8'h00, 6'd0, 1'b0, 4'd15, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_NOP, 8'hFF, 6'd63, 1'b1, 4'd15, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_LINK, 8'h00, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_LINK, 8'h11, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    word_plan.push_back(row(OP_LINK, KIND_KEYS, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 0, 0,
                            8'h00));
    for (int i = 0; i < 7; i++) begin
      word_plan.push_back(row(OP_LINK, 8'hFF, 6'd63, 1'b1, 4'd15, 1'b0, 0, 8'h00, 0, 0,
                              8'h00));
    end
    for (int i = 0; i < 8; i++) begin
      word_plan.push_back(row(OP_LINK, 8'h80 + 8'(i), 6'd0, 1'b0, 4'd0, 1'b0, 0, 8'h00,
                              0, 0, 8'h00));
    end
    word_plan.push_back(row(OP_LINK, 8'h00, 6'd0, 1'b0, 4'd0, 1'b1, 1, KIND_KEYS, 0, 0,
                            8'h00));
    word_plan.push_back(row(OP_KEY, 8'h00, 6'd0, 1'b1, 4'd0, 1'b1, 0, 8'h00, 1, 1, 8'h00));
    word_plan.push_back(row(OP_KEY, 8'h00, 6'd0, 1'b0, 4'd0, 1'b1, 0, 8'h00, 1, 0, 8'h00));
    word_plan.push_back(row(OP_KEY, 8'h00, 6'd13, 1'b1, 4'd0, 1'b1, 0, 8'h00, 0, 0, 8'h00));
    send_plan();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_delimiter(phase_delim[p]);
      plan_random(PHASE_WORDS);
      send_plan();
      drain();
    end

    $display("Run covered %0d words under %0d delimiter settings and three idling patterns.",
             words_sent, NUM_PHASES + 1);
    $display("Frames accepted: %0d (%0d key, %0d code); press events reported: %0d.",
             frames_seen, key_frames, code_frames, events_seen);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d result words were wrong or unexpected.", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: cobs_console_frame_receiver.f
+incdir+design
design/ccfr_pkg.sv
design/ccfr_fifo.sv
design/ccfr_front.sv
design/ccfr_back.sv
design/cobs_console_frame_receiver.sv
tb/cobs_console_frame_receiver_test.sv
